// ===== sv/cna_pkg.sv =====
package cna_pkg;

   localparam int WORD_BITS  = 32;
   localparam int FRAC_BITS  = 16;
   localparam int PROD_BITS  = 2 * WORD_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;
   localparam int WIDE_BITS  = SUM_BITS + 1;
   localparam int ADD_BITS   = WORD_BITS + 1;
   localparam int MAG_BITS   = PROD_BITS;
   localparam int DEN_BITS   = PROD_BITS;
   localparam int NUM_BITS   = MAG_BITS + FRAC_BITS;
   localparam int Q_BITS     = WORD_BITS + 1;
   localparam int REM_BITS   = DEN_BITS + 1;
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS   = PTR_BITS + 1;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_OVF  = 2'd1,
      ST_DIVZ = 2'd2
   } status_type;

   typedef logic signed [WORD_BITS-1:0] word_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   typedef struct packed {
      op_type   op;
      logic     bzero;
      word_type a_re;
      word_type a_im;
      word_type b_re;
      word_type b_im;
   } item_type;

   typedef struct packed {
      word_type val;
      logic     ov;
   } sat_type;

   // one quotient lane of the restoring divider
   typedef struct packed {
      logic                neg;
      logic                big;
      logic [REM_BITS-1:0] rem;
      logic [Q_BITS-1:0]   mlow;
      logic [Q_BITS-1:0]   q;
   } div_part_type;

   function automatic sat_type sat_word(input logic signed [WIDE_BITS-1:0] x);
      sat_type                      r;
      logic signed [WIDE_BITS-1:0]  hi;
      logic signed [WIDE_BITS-1:0]  lo;
      hi = WIDE_BITS'(WORD_MAX);
      lo = WIDE_BITS'(WORD_MIN);
      if (x > hi) begin
         r.val = WORD_MAX;
         r.ov  = 1'b1;
      end else if (x < lo) begin
         r.val = WORD_MIN;
         r.ov  = 1'b1;
      end else begin
         r.val = x[WORD_BITS-1:0];
         r.ov  = 1'b0;
      end
      return r;
   endfunction

   // 2F fraction bits -> F, nearest, ties away from zero
   function automatic logic signed [WIDE_BITS-1:0] round_prod(
      input logic signed [SUM_BITS-1:0] x);
      logic                        neg;
      logic [SUM_BITS-1:0]         mag;
      logic [SUM_BITS-1:0]         sh;
      logic signed [WIDE_BITS-1:0] w;
      neg = x[SUM_BITS-1];
      mag = neg ? SUM_BITS'(-x) : SUM_BITS'(x);
      sh  = (mag + (SUM_BITS'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      w   = signed'({1'b0, sh});
      return neg ? -w : w;
   endfunction

endpackage

// ===== sv/cna_if.sv =====
interface cna_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    op;
   logic signed [cna_pkg::WORD_BITS-1:0] a_re;
   logic signed [cna_pkg::WORD_BITS-1:0] a_im;
   logic signed [cna_pkg::WORD_BITS-1:0] b_re;
   logic signed [cna_pkg::WORD_BITS-1:0] b_im;

   modport source (output valid, op, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, op, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cna_rsp_if;
   logic                          valid;
   logic                          ready;
   logic signed [cna_pkg::WORD_BITS-1:0] res_re;
   logic signed [cna_pkg::WORD_BITS-1:0] res_im;
   logic [1:0]                    status;

   modport source (output valid, res_re, res_im, status, input ready);
   modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

// ===== sv/cna_front.sv =====
module cna_front
   import cna_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   cna_req_if.sink  req,
   output item_type head_o,
   output logic     head_valid_o,
   input  logic     pop_i
);

   item_type            mem_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0] wr_ff, rd_ff;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   item_type            item_in;
   logic                push, pop;

   assign req.ready    = (cnt_ff != CNT_BITS'(FIFO_DEPTH));
   assign push         = req.valid && req.ready;
   assign head_valid_o = (cnt_ff != '0);
   assign pop          = pop_i && head_valid_o;
   assign head_o       = mem_ff[rd_ff];

   // classify on entry: decoded op and zero divisor flag
   always_comb begin
      item_in.op    = op_type'(req.op);
      item_in.bzero = (req.b_re == '0) && (req.b_im == '0);
      item_in.a_re  = req.a_re;
      item_in.a_im  = req.a_im;
      item_in.b_re  = req.b_re;
      item_in.b_im  = req.b_im;
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + PTR_BITS'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + PTR_BITS'(1);
         end
         cnt_ff <= cnt_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(FIFO_DEPTH))
      else $error("queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop_i |-> head_valid_o)
      else $error("pop from empty queue");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (wr_ff == rd_ff))
      else $error("empty queue with pointers apart");

endmodule

// ===== sv/cna_div_stage.sv =====
module cna_div_stage
   import cna_pkg::*;
(
   input  div_part_type        part_i,
   input  logic [DEN_BITS-1:0] den_i,
   output div_part_type        part_o
);

   logic [REM_BITS-1:0] trial;
   logic                fits;

   always_comb begin
      trial = {part_i.rem[REM_BITS-2:0], part_i.mlow[Q_BITS-1]};
      fits  = (trial >= {1'b0, den_i});
      part_o      = part_i;
      part_o.mlow = {part_i.mlow[Q_BITS-2:0], 1'b0};
      part_o.rem  = fits ? (trial - {1'b0, den_i}) : trial;
      part_o.q    = {part_i.q[Q_BITS-2:0], fits};
   end

endmodule

// ===== sv/cna_back.sv =====
module cna_back
   import cna_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  item_type  head_i,
   input  logic      head_valid_i,
   output logic      pop_o,
   cna_rsp_if.source rsp
);

   typedef struct packed {
      op_type                      op;
      logic                        bzero;
      logic signed [PROD_BITS-1:0] rr, ii, ri, ir, br2, bi2;
      logic signed [ADD_BITS-1:0]  add_re, add_im;
   } prod_type;

   typedef struct packed {
      op_type                      op;
      logic                        bzero;
      logic signed [SUM_BITS-1:0]  n_re, n_im;
      logic [DEN_BITS-1:0]         den;
      logic signed [ADD_BITS-1:0]  add_re, add_im;
   } sum_type;

   typedef struct packed {
      op_type              op;
      logic                bzero;
      word_type            re, im;
      logic                ov;
      logic [DEN_BITS-1:0] den;
      div_part_type        pre, pim;
   } stage_type;

   prod_type     p_ff, p_in;
   sum_type      s_ff, s_in;
   stage_type    st_ff [Q_BITS+1];
   stage_type    st_in [Q_BITS+1];
   div_part_type step_re [1:Q_BITS];
   div_part_type step_im [1:Q_BITS];
   logic         pv_ff, sv_ff;
   logic [Q_BITS:0] dv_ff;
   logic         out_valid_ff;
   word_type     out_re_ff, out_re_in, out_im_ff, out_im_in;
   status_type   out_st_ff, out_st_in;
   logic         adv;

   function automatic div_part_type div_prep(input logic signed [SUM_BITS-1:0] num,
                                             input logic [DEN_BITS-1:0] den);
      div_part_type        r;
      logic [MAG_BITS-1:0] mag;
      logic [NUM_BITS-1:0] m;
      r.neg  = num[SUM_BITS-1];
      mag    = r.neg ? MAG_BITS'(-num) : MAG_BITS'(num);
      m      = {mag, {FRAC_BITS{1'b0}}};
      r.big  = (DEN_BITS'(m[NUM_BITS-1:Q_BITS]) >= den);
      r.rem  = REM_BITS'(m[NUM_BITS-1:Q_BITS]);
      r.mlow = m[Q_BITS-1:0];
      r.q    = '0;
      return r;
   endfunction

   function automatic sat_type div_final(input div_part_type p,
                                         input logic [DEN_BITS-1:0] den);
      logic [Q_BITS:0]             qr;
      logic signed [WIDE_BITS-1:0] w;
      sat_type                     r;
      qr = {1'b0, p.q} + (Q_BITS+1)'({p.rem[REM_BITS-2:0], 1'b0} >= {1'b0, den});
      w  = WIDE_BITS'(signed'({1'b0, qr}));
      if (p.neg) begin
         w = -w;
      end
      if (p.big) begin
         r.val = p.neg ? WORD_MIN : WORD_MAX;
         r.ov  = 1'b1;
      end else begin
         r = sat_word(w);
      end
      return r;
   endfunction

   assign adv   = !out_valid_ff || rsp.ready;
   assign pop_o = adv && head_valid_i;

   // products and plain sums
   always_comb begin
      p_in.op     = head_i.op;
      p_in.bzero  = head_i.bzero;
      p_in.rr     = head_i.a_re * head_i.b_re;
      p_in.ii     = head_i.a_im * head_i.b_im;
      p_in.ri     = head_i.a_re * head_i.b_im;
      p_in.ir     = head_i.a_im * head_i.b_re;
      p_in.br2    = head_i.b_re * head_i.b_re;
      p_in.bi2    = head_i.b_im * head_i.b_im;
      if (head_i.op == OP_SUB) begin
         p_in.add_re = ADD_BITS'(head_i.a_re) - ADD_BITS'(head_i.b_re);
         p_in.add_im = ADD_BITS'(head_i.a_im) - ADD_BITS'(head_i.b_im);
      end else begin
         p_in.add_re = ADD_BITS'(head_i.a_re) + ADD_BITS'(head_i.b_re);
         p_in.add_im = ADD_BITS'(head_i.a_im) + ADD_BITS'(head_i.b_im);
      end
   end

   // cross sums and squared modulus
   always_comb begin
      s_in.op     = p_ff.op;
      s_in.bzero  = p_ff.bzero;
      s_in.add_re = p_ff.add_re;
      s_in.add_im = p_ff.add_im;
      s_in.den    = DEN_BITS'(p_ff.br2) + DEN_BITS'(p_ff.bi2);
      if (p_ff.op == OP_DIV) begin
         s_in.n_re = SUM_BITS'(p_ff.rr) + SUM_BITS'(p_ff.ii);
         s_in.n_im = SUM_BITS'(p_ff.ir) - SUM_BITS'(p_ff.ri);
      end else begin
         s_in.n_re = SUM_BITS'(p_ff.rr) - SUM_BITS'(p_ff.ii);
         s_in.n_im = SUM_BITS'(p_ff.ri) + SUM_BITS'(p_ff.ir);
      end
   end

   // finish add/sub/mul, set up the dividers
   always_comb begin
      sat_type sr, si;
      sr = '0;
      si = '0;
      st_in[0].op    = s_ff.op;
      st_in[0].bzero = s_ff.bzero;
      st_in[0].den   = s_ff.den;
      st_in[0].pre   = div_prep(s_ff.n_re, s_ff.den);
      st_in[0].pim   = div_prep(s_ff.n_im, s_ff.den);
      unique case (s_ff.op)
         OP_ADD, OP_SUB: begin
            sr = sat_word(WIDE_BITS'(s_ff.add_re));
            si = sat_word(WIDE_BITS'(s_ff.add_im));
         end
         OP_MUL: begin
            sr = sat_word(round_prod(s_ff.n_re));
            si = sat_word(round_prod(s_ff.n_im));
         end
         OP_DIV: begin
            sr = '0;
            si = '0;
         end
      endcase
      st_in[0].re = sr.val;
      st_in[0].im = si.val;
      st_in[0].ov = sr.ov || si.ov;
   end

   genvar k;
   for (k = 1; k <= Q_BITS; k++) begin : g_div
      cna_div_stage u_re (
         .part_i (st_ff[k-1].pre),
         .den_i  (st_ff[k-1].den),
         .part_o (step_re[k])
      );
      cna_div_stage u_im (
         .part_i (st_ff[k-1].pim),
         .den_i  (st_ff[k-1].den),
         .part_o (step_im[k])
      );
      always_comb begin
         st_in[k]     = st_ff[k-1];
         st_in[k].pre = step_re[k];
         st_in[k].pim = step_im[k];
      end
   end

   // rounding and clamping of the quotients, result selection
   always_comb begin
      sat_type qre, qim;
      qre = div_final(st_ff[Q_BITS].pre, st_ff[Q_BITS].den);
      qim = div_final(st_ff[Q_BITS].pim, st_ff[Q_BITS].den);
      if (st_ff[Q_BITS].op != OP_DIV) begin
         out_re_in = st_ff[Q_BITS].re;
         out_im_in = st_ff[Q_BITS].im;
         out_st_in = st_ff[Q_BITS].ov ? ST_OVF : ST_OK;
      end else if (st_ff[Q_BITS].bzero) begin
         out_re_in = '0;
         out_im_in = '0;
         out_st_in = ST_DIVZ;
      end else begin
         out_re_in = qre.val;
         out_im_in = qim.val;
         out_st_in = (qre.ov || qim.ov) ? ST_OVF : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff <= p_in;
         s_ff <= s_in;
         for (int i = 0; i <= Q_BITS; i++) begin
            st_ff[i] <= st_in[i];
         end
         out_re_ff <= out_re_in;
         out_im_ff <= out_im_in;
         out_st_ff <= out_st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff        <= 1'b0;
         sv_ff        <= 1'b0;
         dv_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         pv_ff        <= head_valid_i;
         sv_ff        <= pv_ff;
         dv_ff        <= {dv_ff[Q_BITS-1:0], sv_ff};
         out_valid_ff <= dv_ff[Q_BITS];
      end
   end

   assign rsp.valid  = out_valid_ff;
   assign rsp.res_re = out_re_ff;
   assign rsp.res_im = out_im_ff;
   assign rsp.status = out_st_ff;

endmodule

// ===== sv/complex_number_alu.sv =====
// channel  | dir | handshake             | payload
// req_chan | in  | req_chan.valid/ready  | op, a_re, a_im, b_re, b_im
// rsp_chan | out | rsp_chan.valid/ready  | res_re, res_im, status
//
// One item per cycle sustained while rsp_chan is ready; every item takes the same
// path, through the 33-step quotient pipeline.
// Synchronous active-high reset clears queue and valid bits only.
// A stall on rsp_chan freezes the back pipeline; the 4-entry input queue
// keeps req_chan ready until it fills.
module complex_number_alu
   import cna_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   cna_req_if.sink   req_chan,
   cna_rsp_if.source rsp_chan
);

   item_type head;
   logic     head_valid;
   logic     pop;

   // front: accept, decode op, flag zero divisor, queue
   cna_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .head_o       (head),
      .head_valid_o (head_valid),
      .pop_i        (pop)
   );

   // back: multipliers, sums, divider lanes, rounding, output register
   cna_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_i       (head),
      .head_valid_i (head_valid),
      .pop_o        (pop),
      .rsp          (rsp_chan)
   );

   // divide by complex zero always yields zero parts
   a_divz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == ST_DIVZ) |->
      (rsp_chan.res_re == '0 && rsp_chan.res_im == '0))
      else $error("divide by zero with non-zero result");

   // overflow means at least one part sits on a bound
   a_ovf_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == ST_OVF) |->
      (rsp_chan.res_re == WORD_MAX || rsp_chan.res_re == WORD_MIN ||
       rsp_chan.res_im == WORD_MAX || rsp_chan.res_im == WORD_MIN))
      else $error("overflow status without clamped part");

   // status never carries the unused code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.status != 2'd3))
      else $error("unused status code");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid straight after reset");

endmodule

// ===== tb/complex_result_checker.sv =====
module complex_result_checker
   import cna_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   cna_req_if    req_chan,
   cna_rsp_if    rsp_chan,
   output int    fail_count,
   output int    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [191:0] wide_type;
   typedef logic [191:0]        mag_type;

   typedef struct {
      word_type   re;
      word_type   im;
      status_type status;
   } cplx_result_type;

   cplx_result_type expected_results[$];

   function automatic word_type clamp_part(input wide_type x, inout logic ov);
      if (x > wide_type'(WORD_MAX)) begin
         ov = 1'b1;
         return WORD_MAX;
      end
      if (x < wide_type'(WORD_MIN)) begin
         ov = 1'b1;
         return WORD_MIN;
      end
      return x[WORD_BITS-1:0];
   endfunction

   // drop FRAC_BITS fraction bits, nearest, ties away from zero
   function automatic wide_type round_half_away(input wide_type x);
      mag_type m;
      m = (x < 0) ? mag_type'(-x) : mag_type'(x);
      m = (m + (mag_type'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      return (x < 0) ? -wide_type'(m) : wide_type'(m);
   endfunction

   function automatic wide_type fixed_quotient(input wide_type n, input wide_type d);
      mag_type m;
      mag_type q;
      mag_type r;
      m = ((n < 0) ? mag_type'(-n) : mag_type'(n)) << FRAC_BITS;
      q = m / mag_type'(d);
      r = m % mag_type'(d);
      if ((r << 1) >= mag_type'(d)) q = q + 1;
      return (n < 0) ? -wide_type'(q) : wide_type'(q);
   endfunction

   function automatic cplx_result_type predict_result(input op_type op,
      input word_type a_re, input word_type a_im,
      input word_type b_re, input word_type b_im);
      cplx_result_type res;
      wide_type ar, ai, br, bi, rr, ri, den;
      logic ov;
      ar = a_re;
      ai = a_im;
      br = b_re;
      bi = b_im;
      ov = 1'b0;
      case (op)
         OP_ADD: begin
            rr = ar + br;
            ri = ai + bi;
         end
         OP_SUB: begin
            rr = ar - br;
            ri = ai - bi;
         end
         OP_MUL: begin
            rr = round_half_away(ar * br - ai * bi);
            ri = round_half_away(ar * bi + ai * br);
         end
         default: begin
            if (br == 0 && bi == 0) begin
               res.re     = '0;
               res.im     = '0;
               res.status = ST_DIVZ;
               return res;
            end
            den = br * br + bi * bi;
            rr  = fixed_quotient(ar * br + ai * bi, den);
            ri  = fixed_quotient(ai * br - ar * bi, den);
         end
      endcase
      res.re     = clamp_part(rr, ov);
      res.im     = clamp_part(ri, ov);
      res.status = ov ? ST_OVF : ST_OK;
      return res;
   endfunction

   assign pending = expected_results.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      cplx_result_type exp_res;
      int              errs;
      errs = 0;
      if (!reset && req_chan.valid && req_chan.ready)
         expected_results.push_back(predict_result(op_type'(req_chan.op),
            req_chan.a_re, req_chan.a_im, req_chan.b_re, req_chan.b_im));
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result item: re %0d im %0d status %0d",
               rsp_chan.res_re, rsp_chan.res_im, rsp_chan.status);
            errs++;
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_chan.res_re !== exp_res.re) begin
               $error("res_re expected %0d actual %0d", exp_res.re, rsp_chan.res_re);
               errs++;
            end
            if (rsp_chan.res_im !== exp_res.im) begin
               $error("res_im expected %0d actual %0d", exp_res.im, rsp_chan.res_im);
               errs++;
            end
            if (rsp_chan.status !== exp_res.status) begin
               $error("status expected %0d actual %0d", exp_res.status,
                  rsp_chan.status);
               errs++;
            end
         end
      end
      if (errs != 0)
         fail_count <= fail_count + errs;
   end
endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   import cna_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1850;
   localparam int IDLE_LIMIT   = 4000;  // cycles with no item on either channel
   localparam int DRAIN_CYCLES = 60;    // pipeline is 37 deep

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   idle_cycles = 0;
   logic hold_request = 1'b0;          // asks the receiver for a long hold-off

   cna_req_if req_chan ();
   cna_rsp_if rsp_chan ();

   complex_number_alu dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   complex_result_checker result_checker (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #1 clock = ~clock;

   // watchdog: nothing moving for too long means the block has hung
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // receiver: stall odds are redrawn per phase, some stretches never stall
   initial rsp_chan.ready = 1'b0;
   always @(posedge clock) begin
      int unsigned hold_left;
      int unsigned phase_cnt;
      int unsigned stall_odds;
      bit          hold_done;
      if (hold_request && !hold_done) begin
         hold_left = 300;               // long enough to fill the input queue
         hold_done = 1'b1;              // one long hold per run
         phase_cnt = 32'hffff_ffff;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (phase_cnt == 32'hffff_ffff || phase_cnt % 64 == 0)
            stall_odds = $urandom_range(0, 3);  // 0: no stalls at all
         if (phase_cnt != 32'hffff_ffff)
            phase_cnt = phase_cnt + 1;
         else
            phase_cnt = 1;
         rsp_chan.ready <= (stall_odds == 0) ? 1'b1
                         : ($urandom_range(0, 7) >= stall_odds + 1);
      end
   end

   // operand mix: full range, small values, extremes and values near one
   function automatic word_type pick_word();
      case ($urandom_range(0, 5))
         0, 1: return word_type'($urandom);
         2:    return word_type'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
         3: begin
            case ($urandom_range(0, 4))
               0: return WORD_MAX;
               1: return WORD_MIN;
               2: return '0;
               3: return word_type'(1);
               default: return word_type'(-1);
            endcase
         end
         4:    return word_type'($signed($urandom_range(0, 1 << 20)) - (1 << 19)) <<< 8;
         default: return word_type'($signed($urandom_range(0, 64)) - 32) <<< FRAC_BITS;
      endcase
   endfunction

   // drive one item and hold it until it is taken; valid stays high afterwards
   task automatic send_item(input op_type op, input word_type a_re, input word_type a_im,
                            input word_type b_re, input word_type b_im);
      req_chan.valid <= 1'b1;
      req_chan.op    <= op;
      req_chan.a_re  <= a_re;
      req_chan.a_im  <= a_im;
      req_chan.b_re  <= b_re;
      req_chan.b_im  <= b_im;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic idle_sender(input int cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   localparam word_type ONE  = word_type'(1) <<< FRAC_BITS;
   localparam word_type HALF = word_type'(1) <<< (FRAC_BITS - 1);

   initial begin
      int burst_left;
      op_type op;
      word_type br, bi;
      req_chan.valid <= 1'b0;
      req_chan.op    <= OP_ADD;
      req_chan.a_re  <= '0;
      req_chan.a_im  <= '0;
      req_chan.b_re  <= '0;
      req_chan.b_im  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every op, saturation, ties, divide by zero
      send_item(OP_ADD, WORD_MAX, WORD_MIN, word_type'(1), word_type'(-1));
      send_item(OP_ADD, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      send_item(OP_ADD, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
      send_item(OP_SUB, WORD_MIN, WORD_MAX, word_type'(1), word_type'(-1));
      send_item(OP_SUB, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX);
      send_item(OP_SUB, '0, '0, '0, '0);
      send_item(OP_MUL, ONE, ONE, ONE, -ONE);
      send_item(OP_MUL, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      send_item(OP_MUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
      send_item(OP_MUL, WORD_MIN, '0, WORD_MIN, '0);
      send_item(OP_MUL, HALF, '0, word_type'(1), '0);     // tie, rounds away
      send_item(OP_MUL, -HALF, '0, word_type'(1), '0);    // negative tie
      send_item(OP_MUL, word_type'(1), word_type'(1), word_type'(1), word_type'(-1));
      send_item(OP_DIV, ONE, ONE, '0, '0);                // complex zero divisor
      send_item(OP_DIV, WORD_MAX, WORD_MIN, '0, '0);
      send_item(OP_DIV, ONE, '0, ONE, ONE);
      send_item(OP_DIV, ONE, '0, word_type'(3) <<< FRAC_BITS, '0);
      send_item(OP_DIV, WORD_MAX, WORD_MAX, word_type'(1), '0); // saturates
      send_item(OP_DIV, WORD_MIN, WORD_MIN, '0, word_type'(-1));
      send_item(OP_DIV, word_type'(1), '0, WORD_MIN, WORD_MIN);
      send_item(OP_DIV, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX);
      send_item(OP_DIV, word_type'(1), '0, word_type'(2), '0); // exact half quotient
      idle_sender(3);

      // random part in bursts with gaps
      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 600)
            hold_request <= 1'b1;    // receiver holds off while items keep coming
         if (n == 1200) begin
            req_chan.valid <= 1'b0;  // wait for everything to drain
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
               idle_sender($urandom_range(1, 12));
         end
         burst_left--;
         op = op_type'($urandom_range(0, 3));
         br = pick_word();
         bi = pick_word();
         if (op == OP_DIV && $urandom_range(0, 15) == 0) begin
            br = '0;
            bi = '0;
         end
         send_item(op, pick_word(), pick_word(), br, bi);
      end
      req_chan.valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end
endmodule
